// File: sv/wfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wfd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] LEN7_MASK  = 7'h7f;
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] OPCODE_MASK = 4'h0f;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_ENOUGH = 1'b1;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] in_byte;
        logic       buffer_last;
    } in_word_t;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] payload_byte;
        logic       frame_end;
        logic       status;
        logic       fin;
        logic [3:0] opcode;
    } out_word_t;

    // Classified byte as handed from the parser to the output side.
    typedef struct packed {
        logic       dv;
        logic [7:0] raw;
        logic [7:0] key;
        logic       fe;
        logic       st;
        logic       fin;
        logic [3:0] op;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t ent;
    } q_wr_t;

    typedef struct packed {
        logic   not_empty;
        entry_t head;
    } q_rd_t;

endpackage

// File: sv/wfd_front.sv
// Header parser: tracks frame phase and classifies each accepted byte.
module wfd_front #(
    parameter int LENGTH_BITS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               q_room,
    input  wfd_pkg::in_word_t  s_data,
    output wfd_pkg::q_wr_t     q_wr
);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_KEY,
        PH_PAY,
        PH_DONE
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic                     fin_reg, fin_next;
    logic [3:0]               op_reg, op_next;
    logic                     mask_reg, mask_next;
    logic [3:0]               ext_cnt_reg, ext_cnt_next;
    logic [LENGTH_BITS-1:0]   rem_reg, rem_next;
    logic [31:0]              key_reg, key_next;
    logic [1:0]               kidx_reg, kidx_next;

    logic                     accept;
    logic                     dv, fe, st;
    logic                     rep_fin;
    logic [3:0]               rep_op;
    logic [7:0]               b;
    logic [6:0]               len7;
    logic [1:0]               ksel;
    logic [7:0]               kbyte;
    logic [LENGTH_BITS-1:0]   ext_len;

    assign accept = s_valid && q_room;
    assign b      = s_data.in_byte;
    assign len7   = b[6:0] & wfd_pkg::LEN7_MASK;
    assign ksel   = 2'd3 - kidx_reg;
    assign kbyte  = key_reg[{ksel, 3'b000} +: 8];

    // Saturate once the next shift would push bits off the top.
    assign ext_len = (rem_reg[LENGTH_BITS-1 -: 8] != 8'd0) ? {LENGTH_BITS{1'b1}}
                   : {rem_reg[LENGTH_BITS-9:0], b};

    always_comb begin
        phase_next   = phase_reg;
        fin_next     = fin_reg;
        op_next      = op_reg;
        mask_next    = mask_reg;
        ext_cnt_next = ext_cnt_reg;
        rem_next     = rem_reg;
        key_next     = key_reg;
        kidx_next    = kidx_reg;
        dv           = 1'b0;
        fe           = 1'b0;
        st           = wfd_pkg::STATUS_OK;

        if (s_data.has_byte) begin
            case (phase_reg)
                PH_HDR0: begin
                    fin_next   = b[7];
                    op_next    = b[3:0] & wfd_pkg::OPCODE_MASK;
                    phase_next = PH_HDR1;
                end
                PH_HDR1: begin
                    mask_next = b[7];
                    key_next  = 32'd0;
                    kidx_next = 2'd0;
                    rem_next  = '0;
                    if (len7 == wfd_pkg::LEN7_EXT16) begin
                        ext_cnt_next = wfd_pkg::EXT16_BYTES;
                        phase_next   = PH_EXT;
                    end else if (len7 == wfd_pkg::LEN7_EXT64) begin
                        ext_cnt_next = wfd_pkg::EXT64_BYTES;
                        phase_next   = PH_EXT;
                    end else begin
                        rem_next = LENGTH_BITS'(len7);
                        if (b[7]) begin
                            phase_next = PH_KEY;
                        end else if (len7 == 7'd0) begin
                            phase_next = PH_DONE;
                            fe         = 1'b1;
                        end else begin
                            phase_next = PH_PAY;
                        end
                    end
                end
                PH_EXT: begin
                    rem_next     = ext_len;
                    ext_cnt_next = ext_cnt_reg - 4'd1;
                    if (ext_cnt_reg == 4'd1) begin
                        kidx_next = 2'd0;
                        if (mask_reg) begin
                            phase_next = PH_KEY;
                        end else if (ext_len == '0) begin
                            phase_next = PH_DONE;
                            fe         = 1'b1;
                        end else begin
                            phase_next = PH_PAY;
                        end
                    end
                end
                PH_KEY: begin
                    key_next  = {key_reg[23:0], b};
                    kidx_next = kidx_reg + 2'd1;
                    if (kidx_reg == 2'd3) begin
                        if (rem_reg == '0) begin
                            phase_next = PH_DONE;
                            fe         = 1'b1;
                        end else begin
                            phase_next = PH_PAY;
                        end
                    end
                end
                PH_PAY: begin
                    dv        = 1'b1;
                    kidx_next = kidx_reg + 2'd1;
                    rem_next  = rem_reg - LENGTH_BITS'(1);
                    // last payload byte closes the frame
                    if (rem_reg == LENGTH_BITS'(1)) begin
                        fe         = 1'b1;
                        phase_next = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end

        rep_fin = fin_next;
        rep_op  = op_next;

        if (s_data.buffer_last) begin
            if (phase_next != PH_DONE) begin
                fe = 1'b1;
                st = wfd_pkg::STATUS_NOT_ENOUGH;
            end
            phase_next = PH_HDR0;
            fin_next   = 1'b0;
            op_next    = 4'd0;
        end
    end

    always_comb begin
        q_wr.push    = accept && (dv || fe);
        q_wr.ent.dv  = dv;
        q_wr.ent.raw = b;
        q_wr.ent.key = kbyte;
        q_wr.ent.fe  = fe;
        q_wr.ent.st  = st;
        q_wr.ent.fin = rep_fin;
        q_wr.ent.op  = rep_op;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR0;
            fin_reg     <= 1'b0;
            op_reg      <= 4'd0;
            mask_reg    <= 1'b0;
            ext_cnt_reg <= 4'd0;
            rem_reg     <= '0;
            key_reg     <= 32'd0;
            kidx_reg    <= 2'd0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            fin_reg     <= fin_next;
            op_reg      <= op_next;
            mask_reg    <= mask_next;
            ext_cnt_reg <= ext_cnt_next;
            rem_reg     <= rem_next;
            key_reg     <= key_next;
            kidx_reg    <= kidx_next;
        end
    end

    a_ext_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_EXT |-> ext_cnt_reg != 4'd0)
        else $error("extended length phase with no bytes left");

    a_pay_remaining: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAY |-> rem_reg != '0)
        else $error("payload phase with zero bytes remaining");

endmodule

// File: sv/wfd_queue.sv
// Short queue between the parser and the output stage.
module wfd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  wfd_pkg::q_wr_t  q_wr,
    input  logic            pop,
    output logic            room,
    output wfd_pkg::q_rd_t  q_rd
);

    wfd_pkg::entry_t              mem [wfd_pkg::QUEUE_DEPTH];
    logic [wfd_pkg::QPTR_W-1:0]   wptr_reg, rptr_reg;
    logic [wfd_pkg::QCNT_W-1:0]   cnt_reg;
    logic                         do_pop;

    assign room         = cnt_reg != wfd_pkg::QCNT_W'(wfd_pkg::QUEUE_DEPTH);
    assign q_rd.not_empty = cnt_reg != '0;
    assign q_rd.head    = mem[rptr_reg];
    assign do_pop       = pop && q_rd.not_empty;

    always_ff @(posedge aclk) begin
        if (q_wr.push) begin
            mem[wptr_reg] <= q_wr.ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (q_wr.push) begin
                wptr_reg <= wptr_reg + wfd_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + wfd_pkg::QPTR_W'(1);
            end
            case ({q_wr.push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + wfd_pkg::QCNT_W'(1);
                2'b01:   cnt_reg <= cnt_reg - wfd_pkg::QCNT_W'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_wr.push |-> room)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= wfd_pkg::QCNT_W'(wfd_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// File: sv/wfd_back.sv
// Output stage: unmasks payload bytes and holds the result word for the sink.
module wfd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  wfd_pkg::q_rd_t      q_rd,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output wfd_pkg::out_word_t  m_data
);

    logic                m_valid_reg;
    wfd_pkg::out_word_t  out_reg, out_next;

    assign pop     = q_rd.not_empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        out_next.data_valid   = q_rd.head.dv;
        out_next.payload_byte = q_rd.head.dv ? (q_rd.head.raw ^ q_rd.head.key) : 8'd0;
        out_next.frame_end    = q_rd.head.fe;
        out_next.status       = q_rd.head.fe ? q_rd.head.st : 1'b0;
        out_next.fin          = q_rd.head.fe ? q_rd.head.fin : 1'b0;
        out_next.opcode       = q_rd.head.fe ? q_rd.head.op : 4'd0;
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

endmodule

// File: sv/websocket_frame_deframer.sv
// WebSocket frame deframer: takes one buffer byte per word on s_ and emits
// unmasked payload bytes and a frame report on m_. It sustains one input word
// per clock cycle: the header parser settles each byte combinationally, and a
// four-word queue plus an output register separate it from the sink, so the
// input stalls only when the queue is full. A result word passes through the
// queue and the output register before it is presented on m_. Lengths wider
// than LENGTH_BITS saturate to all ones.
module websocket_frame_deframer #(
    parameter int LENGTH_BITS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wfd_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output wfd_pkg::out_word_t  m_data
);

    wfd_pkg::q_wr_t  q_wr;
    wfd_pkg::q_rd_t  q_rd;
    logic            q_room;
    logic            pop;

    assign s_ready = q_room;

    wfd_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .q_room  (q_room),
        .s_data  (s_data),
        .q_wr    (q_wr)
    );

    wfd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .pop     (pop),
        .room    (q_room),
        .q_rd    (q_rd)
    );

    wfd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_rd    (q_rd),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: test/wfd_deframe_checker.sv
// Checker for the frame deframer: predicts output words from accepted input words and compares.
module wfd_deframe_checker #(
    parameter int LENGTH_BITS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  wfd_pkg::in_word_t   s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  wfd_pkg::out_word_t  m_data,
    output int                  error_count,
    output int                  pending
);

    localparam logic [63:0] LEN_LIMIT =
        (LENGTH_BITS >= 64) ? '1 : ((64'd1 << LENGTH_BITS) - 64'd1);

    typedef enum logic [2:0] {
        PH_HEADER0,
        PH_HEADER1,
        PH_EXTLEN,
        PH_MASKKEY,
        PH_PAYLOAD,
        PH_DONE
    } parse_phase_t;

    parse_phase_t ph;
    logic         fin_q;
    logic [3:0]   op_q;
    logic         masked_q;
    logic [3:0]   ext_left;
    logic [63:0]  pay_total;
    logic [63:0]  pay_seen;
    logic [31:0]  key_q;
    logic [1:0]   key_pos;

    wfd_pkg::out_word_t deframed_q[$];

    // Header complete: a zero-length frame is finished right here.
    function automatic logic begin_payload();
        key_pos  = '0;
        pay_seen = '0;
        if (pay_total == 64'd0) begin
            ph = PH_DONE;
            return 1'b1;
        end
        ph = PH_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic logic length_known();
        if (masked_q) begin
            key_pos = '0;
            ph      = PH_MASKKEY;
            return 1'b0;
        end
        return begin_payload();
    endfunction

    task automatic deframe_byte(input wfd_pkg::in_word_t w);
        logic               dv;
        logic               fe;
        logic               st;
        logic [7:0]         pb;
        logic [7:0]         kb;
        logic               rep_fin;
        logic [3:0]         rep_op;
        wfd_pkg::out_word_t o;
        dv = 1'b0;
        fe = 1'b0;
        st = wfd_pkg::STATUS_OK;
        pb = '0;
        if (w.has_byte) begin
            case (ph)
                PH_HEADER0: begin
                    fin_q = w.in_byte[7];
                    op_q  = w.in_byte[3:0] & wfd_pkg::OPCODE_MASK;
                    ph    = PH_HEADER1;
                end
                PH_HEADER1: begin
                    masked_q  = w.in_byte[7];
                    key_q     = '0;
                    key_pos   = '0;
                    pay_seen  = '0;
                    pay_total = '0;
                    if ((w.in_byte[6:0] & wfd_pkg::LEN7_MASK) == wfd_pkg::LEN7_EXT16) begin
                        ext_left = wfd_pkg::EXT16_BYTES;
                        ph       = PH_EXTLEN;
                    end else if ((w.in_byte[6:0] & wfd_pkg::LEN7_MASK) == wfd_pkg::LEN7_EXT64) begin
                        ext_left = wfd_pkg::EXT64_BYTES;
                        ph       = PH_EXTLEN;
                    end else begin
                        pay_total = 64'(w.in_byte[6:0]) & LEN_LIMIT;
                        fe        = length_known();
                    end
                end
                PH_EXTLEN: begin
                    // saturate once another byte would overflow the length
                    if (pay_total > (LEN_LIMIT >> 8))
                        pay_total = LEN_LIMIT;
                    else
                        pay_total = {pay_total[55:0], w.in_byte};
                    ext_left = ext_left - 4'd1;
                    if (ext_left == 4'd0)
                        fe = length_known();
                end
                PH_MASKKEY: begin
                    key_q   = {key_q[23:0], w.in_byte};
                    key_pos = key_pos + 2'd1;
                    if (key_pos == 2'd0)
                        fe = begin_payload();
                end
                PH_PAYLOAD: begin
                    kb       = 8'(key_q >> (8 * (3 - int'(key_pos))));
                    pb       = w.in_byte ^ kb;
                    dv       = 1'b1;
                    key_pos  = key_pos + 2'd1;
                    pay_seen = pay_seen + 64'd1;
                    if (pay_seen >= pay_total) begin
                        fe = 1'b1;
                        ph = PH_DONE;
                    end
                end
                default: ;
            endcase
        end
        rep_fin = fin_q;
        rep_op  = op_q;
        if (w.buffer_last) begin
            if (ph != PH_DONE) begin
                fe = 1'b1;
                st = wfd_pkg::STATUS_NOT_ENOUGH;
            end
            ph    = PH_HEADER0;
            fin_q = 1'b0;
            op_q  = '0;
        end
        if (dv || fe) begin
            o.data_valid   = dv;
            o.payload_byte = dv ? pb : 8'h00;
            o.frame_end    = fe;
            o.status       = fe ? st : wfd_pkg::STATUS_OK;
            o.fin          = fe ? rep_fin : 1'b0;
            o.opcode       = fe ? rep_op : 4'h0;
            deframed_q.push_back(o);
        end
    endtask

    always @(posedge aclk) begin : watch
        wfd_pkg::out_word_t want;
        logic               bad;
        if (!aresetn) begin
            ph          = PH_HEADER0;
            fin_q       = 1'b0;
            op_q        = '0;
            masked_q    = 1'b0;
            ext_left    = '0;
            pay_total   = '0;
            pay_seen    = '0;
            key_q       = '0;
            key_pos     = '0;
            error_count = 0;
            deframed_q.delete();
        end else begin
            if (s_valid && s_ready)
                deframe_byte(s_data);
            if (m_valid && m_ready) begin
                if (deframed_q.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected dv=%0d byte=%02h fe=%0d st=%0d fin=%0d op=%0h",
                                 m_data.data_valid, m_data.payload_byte, m_data.frame_end,
                                 m_data.status, m_data.fin, m_data.opcode);
                end else begin
                    want = deframed_q.pop_front();
                    bad  = (m_data.data_valid !== want.data_valid)
                        || (m_data.payload_byte !== want.payload_byte)
                        || (m_data.frame_end !== want.frame_end)
                        || (m_data.status !== want.status)
                        || (m_data.fin !== want.fin)
                        || (m_data.opcode !== want.opcode);
                    if (bad) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("expected dv=%0d byte=%02h fe=%0d st=%0d fin=%0d op=%0h",
                                     want.data_valid, want.payload_byte, want.frame_end,
                                     want.status, want.fin, want.opcode);
                            $display("actual   dv=%0d byte=%02h fe=%0d st=%0d fin=%0d op=%0h",
                                     m_data.data_valid, m_data.payload_byte, m_data.frame_end,
                                     m_data.status, m_data.fin, m_data.opcode);
                        end
                    end
                end
            end
        end
        pending = deframed_q.size();
    end

endmodule

// File: test/tb_websocket_frame_deframer.sv
// Testbench top for the frame deframer: clock, reset, buffer stimulus and the verdict.
module tb_websocket_frame_deframer;

    localparam int LENGTH_BITS = 64;
    localparam int ITEMS       = 2000;
    localparam int STALL_LIMIT = 4000;
    localparam int N_DIRECTED  = 30;

    // Directed words as {has_byte, in_byte, buffer_last}.
    localparam logic [9:0] DIRECTED_WORDS [N_DIRECTED] = '{
        {1'b0, 8'h5A, 1'b1},                                          // empty buffer
        {1'b1, 8'hFF, 1'b1},                                          // only byte 0
        {1'b1, 8'h80, 1'b0}, {1'b1, 8'h00, 1'b0}, {1'b0, 8'h00, 1'b1}, // zero length, end apart
        {1'b1, 8'h01, 1'b0}, {1'b1, 8'h80, 1'b0},                     // masked, zero length
        {1'b1, 8'h00, 1'b0}, {1'b1, 8'hFF, 1'b0},
        {1'b1, 8'h00, 1'b0}, {1'b1, 8'hFF, 1'b1},
        {1'b1, 8'h82, 1'b0}, {1'b1, 8'h82, 1'b0},                     // masked, two bytes
        {1'b1, 8'hAA, 1'b0}, {1'b1, 8'h55, 1'b0},
        {1'b1, 8'hFF, 1'b0}, {1'b1, 8'h00, 1'b0},
        {1'b1, 8'h00, 1'b0}, {1'b1, 8'hFF, 1'b0},
        {1'b1, 8'h7E, 1'b1},                                          // trailing byte, ignored
        {1'b1, 8'h89, 1'b0}, {1'b1, 8'h7E, 1'b0},                     // 16-bit length
        {1'b1, 8'h00, 1'b0}, {1'b1, 8'h01, 1'b0}, {1'b1, 8'hFF, 1'b1},
        {1'b0, 8'hA5, 1'b0},                                          // idle word
        {1'b1, 8'h0A, 1'b0}, {1'b1, 8'hFF, 1'b0},                     // 64-bit length, cut short
        {1'b1, 8'hFF, 1'b0}, {1'b1, 8'hFF, 1'b1}
    };

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    wfd_pkg::in_word_t  s_data;
    logic               m_valid;
    logic               m_ready;
    wfd_pkg::out_word_t m_data;

    int error_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int sent_items;
    int stall_cycles;

    logic [7:0] frame_bytes[$];

    websocket_frame_deframer #(
        .LENGTH_BITS(LENGTH_BITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    wfd_deframe_checker #(
        .LENGTH_BITS(LENGTH_BITS)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .error_count (error_count),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input wfd_pkg::in_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        if (w.has_byte || w.buffer_last)
            sent_items++;
        @(negedge aclk);
    endtask

    // Append one frame; a wild frame takes any length code and is cut short later.
    task automatic build_frame(input bit wild);
        logic [6:0]  code;
        logic [63:0] plen;
        logic        mask;
        int          sel;
        int          nbytes;
        sel = $urandom_range(99);
        if (wild) begin
            code = 7'($urandom_range(127));
            if (code == wfd_pkg::LEN7_EXT64)
                plen = {$urandom, $urandom};
            else if (code == wfd_pkg::LEN7_EXT16)
                plen = 64'($urandom_range(65535));
            else
                plen = 64'(code);
        end else if (sel < 60) begin
            plen = 64'($urandom_range(12));
            code = 7'(plen);
        end else if (sel < 75) begin
            plen = 64'($urandom_range(13, 125));
            code = 7'(plen);
        end else if (sel < 90) begin
            plen = 64'($urandom_range(80));
            code = wfd_pkg::LEN7_EXT16;
        end else begin
            plen = 64'($urandom_range(40));
            code = wfd_pkg::LEN7_EXT64;
        end
        mask = 1'($urandom_range(1));
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back({mask, code});
        if (code == wfd_pkg::LEN7_EXT16) begin
            frame_bytes.push_back(plen[15:8]);
            frame_bytes.push_back(plen[7:0]);
        end else if (code == wfd_pkg::LEN7_EXT64) begin
            for (int i = 7; i >= 0; i--)
                frame_bytes.push_back(plen[8*i +: 8]);
        end
        if (mask)
            repeat (4) frame_bytes.push_back(8'($urandom));
        nbytes = (wild && plen > 64'd20) ? 20 : int'(plen);
        repeat (nbytes) frame_bytes.push_back(8'($urandom));
    endtask

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb_websocket_frame_deframer: done, errors");
        $finish;
    end

    initial begin : stimulus
        int  kind;
        int  cut;
        bit  sep_end;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        sent_items    = 0;
        send_idle_pct = 27;
        recv_idle_pct = 84;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_word(wfd_pkg::in_word_t'(DIRECTED_WORDS[i]));

        while (sent_items < ITEMS) begin
            if (sent_items < ITEMS / 3) begin
                send_idle_pct = 27;
                recv_idle_pct = 84;
            end else if (sent_items < 2 * ITEMS / 3) begin
                send_idle_pct = 84;
                recv_idle_pct = 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            frame_bytes.delete();
            kind = $urandom_range(99);
            if (kind < 70) begin
                build_frame(1'b0);
                if ($urandom_range(9) < 3)
                    repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
            end else if (kind < 90) begin
                build_frame(1'b1);
                cut = $urandom_range(0, frame_bytes.size() - 1);
                while (frame_bytes.size() > cut)
                    void'(frame_bytes.pop_back());
            end else begin
                repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom));
            end

            sep_end = (frame_bytes.size() == 0) || ($urandom_range(3) == 0);
            foreach (frame_bytes[i]) begin
                if ($urandom_range(19) == 0)
                    send_word({1'b0, 8'($urandom), 1'b0});
                send_word({1'b1, frame_bytes[i],
                           1'(!sep_end && (i == frame_bytes.size() - 1))});
            end
            if (sep_end)
                send_word({1'b0, 8'($urandom), 1'b1});
        end

        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (error_count == 0)
            $display("tb_websocket_frame_deframer: done, clean");
        else
            $display("tb_websocket_frame_deframer: done, errors");
        $finish;
    end

endmodule

// File: websocket_frame_deframer.f
sv/wfd_pkg.sv
sv/wfd_front.sv
sv/wfd_queue.sv
sv/wfd_back.sv
sv/websocket_frame_deframer.sv
test/wfd_deframe_checker.sv
test/tb_websocket_frame_deframer.sv
